// File: hdl/wildcard_byte_signature_scan_core_macros.svh
// assertion macros used by the checker file
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_CORE_MACROS_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_CORE_MACROS_SVH

// clocked assertion, held off while reset is low
`define WBSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion of the form antecedent |=> consequent
`define WBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wbss_pkg.sv
`timescale 1ns / 1ps

package wbss_pkg;

    // sizing
    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int REG_BYTES   = 16;
    localparam int WIN_DEPTH   = MAX_PATTERN;
    localparam int EFF_MAX     = (REG_BYTES < WIN_DEPTH) ? REG_BYTES : WIN_DEPTH;
    localparam int WIN_IDX_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int CARE_W     = 16;
    localparam int LEN_W      = 5;
    localparam int OUT_OFFS_W = 32;
    localparam int PADDR_W    = 5;

    // register map, one 64-bit register every 8 bytes
    typedef enum logic [1:0] {
        REG_PAT_LO = 2'd0,
        REG_PAT_HI = 2'd1,
        REG_CARE   = 2'd2,
        REG_LEN    = 2'd3
    } t_reg_idx;

    // pattern setup seen by the compare logic
    typedef struct packed {
        logic [WORD_W-1:0] pat_lo;
        logic [WORD_W-1:0] pat_hi;
        logic [CARE_W-1:0] care;
        logic [LEN_W-1:0]  len;
    } t_cfg;

    // outcome of the request sitting in the input register
    typedef struct packed {
        logic                  produce;
        logic                  found;
        logic [OUT_OFFS_W-1:0] offset;
    } t_match;

endpackage

// File: hdl/wbss_if.sv
`timescale 1ns / 1ps

// scan byte channel
interface wbss_scan_if import wbss_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              read_ok;
    logic              last_byte;

    modport source (output valid, data_byte, read_ok, last_byte, input ready);
    modport sink   (input valid, data_byte, read_ok, last_byte, output ready);
endinterface

// search result channel
interface wbss_result_if import wbss_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [OUT_OFFS_W-1:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

// File: hdl/wbss_cfg_regs.sv
`timescale 1ns / 1ps

module wbss_cfg_regs import wbss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [WORD_W-1:0] r_pat_lo;
    logic [WORD_W-1:0] r_pat_hi;
    logic [CARE_W-1:0] r_care;
    logic [LEN_W-1:0]  r_len;
    t_reg_idx          w_idx;
    logic              w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_len    <= LEN_W'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PAT_LO: r_pat_lo <= pwdata;
                REG_PAT_HI: r_pat_hi <= pwdata;
                REG_CARE:   r_care   <= pwdata[CARE_W-1:0];
                REG_LEN:    r_len    <= pwdata[LEN_W-1:0];
                default:    r_len    <= r_len;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_PAT_LO: prdata = r_pat_lo;
            REG_PAT_HI: prdata = r_pat_hi;
            REG_CARE:   prdata = WORD_W'(r_care);
            REG_LEN:    prdata = WORD_W'(r_len);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{pat_lo: r_pat_lo, pat_hi: r_pat_hi, care: r_care, len: r_len};

endmodule

// File: hdl/wbss_window_match.sv
`timescale 1ns / 1ps

module wbss_window_match import wbss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_advance,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_read_ok,
    input  logic              i_last_byte,
    output t_match            o_match
);

    logic [BYTE_W-1:0]      r_byte_win [WIN_DEPTH];
    logic [WIN_DEPTH-1:0]   r_ok_win;
    logic [OFFSET_BITS-1:0] r_count;
    logic                   r_done;

    logic [BYTE_W-1:0]      n_byte_win [WIN_DEPTH];
    logic [WIN_DEPTH-1:0]   n_ok_win;
    logic [OFFSET_BITS-1:0] n_count;
    logic [LEN_W-1:0]       w_len;
    logic [LEN_W-1:0]       w_len_m1;
    logic                   w_cmp_ok;
    logic                   w_full;
    logic                   w_hit;
    logic [OFFSET_BITS-1:0] w_offs;
    logic [2*WORD_W-1:0]    w_pat;

    // effective pattern length, zero counts as one, clamped to the window
    always_comb begin
        if (i_cfg.len == '0) begin
            w_len = LEN_W'(1);
        end else if (i_cfg.len > LEN_W'(EFF_MAX)) begin
            w_len = LEN_W'(EFF_MAX);
        end else begin
            w_len = i_cfg.len;
        end
    end

    assign w_len_m1 = w_len - LEN_W'(1);
    assign w_pat    = {i_cfg.pat_hi, i_cfg.pat_lo};

    // window after shifting in the current byte, entry 0 newest
    always_comb begin
        n_byte_win[0] = i_data_byte;
        n_ok_win[0]   = i_read_ok;
        for (int k = 1; k < WIN_DEPTH; k++) begin
            n_byte_win[k] = r_byte_win[k-1];
            n_ok_win[k]   = r_ok_win[k-1];
        end
    end

    // masked compare, pattern byte i against the byte of age len-1-i
    always_comb begin
        logic [LEN_W-1:0] age;
        w_cmp_ok = 1'b1;
        for (int i = 0; i < EFF_MAX; i++) begin
            age = w_len_m1 - LEN_W'(i);
            if (LEN_W'(i) < w_len) begin
                if (!n_ok_win[age[WIN_IDX_W-1:0]]) begin
                    w_cmp_ok = 1'b0;
                end
                if (i_cfg.care[i] &&
                    (n_byte_win[age[WIN_IDX_W-1:0]] != w_pat[i*BYTE_W +: BYTE_W])) begin
                    w_cmp_ok = 1'b0;
                end
            end
        end
    end

    assign w_full = (r_count >= OFFSET_BITS'(w_len_m1));
    assign w_hit  = w_full & w_cmp_ok;
    assign w_offs = r_count - OFFSET_BITS'(w_len_m1);

    // saturating byte count
    assign n_count = (r_count == '1) ? r_count : r_count + OFFSET_BITS'(1);

    // result of the request at the input register
    assign o_match.produce = ~r_done & (w_hit | i_last_byte);
    assign o_match.found   = w_hit;
    assign o_match.offset  = w_hit ? w_offs[OUT_OFFS_W-1:0] : '0;

    // window contents, only entries written in this region are ever compared
    always_ff @(posedge i_clk) begin
        if (i_advance && !r_done) begin
            r_byte_win <= n_byte_win;
        end
    end

    // region control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_win <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else if (i_advance) begin
            if (i_last_byte) begin
                r_ok_win <= '0;
                r_count  <= '0;
                r_done   <= 1'b0;
            end else if (!r_done) begin
                r_ok_win <= n_ok_win;
                r_count  <= n_count;
                r_done   <= w_hit;
            end
        end
    end

endmodule

// File: hdl/wildcard_byte_signature_scan_core.sv
`timescale 1ns / 1ps

// Wildcard byte signature scanner. Region bytes arrive one per request, each
// with a read-ok flag and a last-byte marker; the block reports the offset of
// the first window whose cared-for bytes equal the preloaded pattern and whose
// bytes all read fine, or a not-found result on the region's last byte. Bytes
// after a match are dropped until the last byte, which restarts the search.
// One byte is taken every clock cycle unless the input stalls: a request is
// registered at the input, compared against the 16-entry window from the input
// register, and its result is loaded into the output register when the input
// stage moves on. The input stalls only when a byte that yields a result meets
// a result still held by the sink. The user must write the pattern registers
// (64-bit APB, 8-byte stride) only while the scanner is idle; not enforced.
module wildcard_byte_signature_scan_core import wbss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wbss_scan_if.sink          i_scan,
    wbss_result_if.source      o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready
);

    t_cfg                  w_cfg;
    t_match                w_match;
    logic                  w_adv;

    logic                  r_s1_valid;
    logic [BYTE_W-1:0]     r_s1_data;
    logic                  r_s1_ok;
    logic                  r_s1_last;
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [OUT_OFFS_W-1:0] r_out_offset;

    wbss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wbss_window_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_advance   (w_adv),
        .i_data_byte (r_s1_data),
        .i_read_ok   (r_s1_ok),
        .i_last_byte (r_s1_last),
        .o_match     (w_match)
    );

    // the input stage moves on unless its result has nowhere to go
    assign w_adv        = r_s1_valid & (~w_match.produce | ~r_out_valid | o_result.ready);
    assign i_scan.ready = ~r_s1_valid | w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_s1_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_s1_data <= i_scan.data_byte;
            r_s1_ok   <= i_scan.read_ok;
            r_s1_last <= i_scan.last_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_match.produce) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_match.produce) begin
            r_out_found  <= w_match.found;
            r_out_offset <= w_match.offset;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.found        = r_out_found;
    assign o_result.match_offset = r_out_offset;

endmodule

// File: hdl/wbss_checker.sv
`timescale 1ns / 1ps
`include "wildcard_byte_signature_scan_core_macros.svh"

module wbss_checker import wbss_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_found,
    input logic [OUT_OFFS_W-1:0] i_offset
);

    // a not-found result always carries offset zero
    `WBSS_ASSERT(a_notfound_zero, (i_out_valid && !i_found) |-> (i_offset == '0), "not-found result with nonzero offset")

    // with the result register empty the scanner must take a request
    `WBSS_ASSERT(a_ready_when_empty, (!i_out_valid) |-> i_in_ready, "input stalled with empty output")

    // a held result stays put
    `WBSS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_found) && $stable(i_offset), "stalled result changed")

endmodule

bind wildcard_byte_signature_scan_core wbss_checker u_wbss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_scan.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_found     (o_result.found),
    .i_offset    (o_result.match_offset)
);
